[rtl/ffbc_pkg.sv]
package ffbc_pkg;

  // Default sizing
  localparam int unsigned MaxEntriesDef  = 128;
  localparam int unsigned HeaderBytesDef = 56;

  // Field widths
  localparam int unsigned HandleW = 48;
  localparam int unsigned SizeW   = 32;
  localparam int unsigned HeldW   = 8;
  localparam int unsigned LimitW  = 8;

  // Limit register reset value
  localparam logic [LimitW-1:0] LimitReset = 8'd100;

  // Operation codes
  localparam logic OpAlloc   = 1'b0;
  localparam logic OpRelease = 1'b1;

  // One cached block
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [SizeW-1:0]   size;
  } entry_t;

  // Input transaction
  typedef struct packed {
    logic               operation;
    logic [SizeW-1:0]   request_size;
    logic [HandleW-1:0] block_handle;
    logic [SizeW-1:0]   block_bytes;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic               reuse_hit;
    logic [HandleW-1:0] reused_handle;
    logic [SizeW-1:0]   reused_size;
    logic               evict_valid;
    logic [HandleW-1:0] evicted_handle;
    logic [SizeW-1:0]   evicted_size;
    logic [HeldW-1:0]   entries_held;
  } res_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic load_scan;  // capture fit flag and contents
    logic scan_en;    // one doubling step of the first-fit scan
    logic apply;      // close the gap behind the first fit
    logic evict;      // drop the oldest entry, everyone moves down
    logic insert;     // write the new block at the selected cell
  } cell_ctrl_t;

endpackage

[rtl/ffbc_cell.sv]
module ffbc_cell #(
  parameter int unsigned HeaderBytes = 56
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ffbc_pkg::cell_ctrl_t   ctrl_i,
  input  logic                   valid_i,
  input  logic                   ins_here_i,
  input  ffbc_pkg::entry_t       ins_entry_i,
  input  logic [31:0]            req_size_i,
  input  ffbc_pkg::entry_t       nxt_entry_i,
  input  logic [31:0]            nxt_usable_i,
  input  logic                   lft_f_i,
  input  ffbc_pkg::entry_t       lft_d_i,
  output ffbc_pkg::entry_t       entry_o,
  output logic [31:0]            usable_o,
  output logic                   scan_f_o,
  output ffbc_pkg::entry_t       scan_d_o
);
  import ffbc_pkg::*;

  localparam logic [SizeW-1:0] HeaderW = SizeW'(HeaderBytes);

  entry_t           entry_q;
  logic [SizeW-1:0] usable_q;
  logic [SizeW-1:0] ins_usable;
  logic             scan_f_q;
  entry_t           scan_d_q;
  logic             move_down;

  // Usable bytes of the incoming block, saturating at zero
  assign ins_usable = (ins_entry_i.size > HeaderW) ? ins_entry_i.size - HeaderW : '0;

  // Take the upper neighbor on eviction or behind a removed fit
  assign move_down = ctrl_i.evict | (ctrl_i.apply & scan_f_q);

  // Stored block
  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert && ins_here_i) begin
      entry_q  <= ins_entry_i;
      usable_q <= ins_usable;
    end else if (move_down) begin
      entry_q  <= nxt_entry_i;
      usable_q <= nxt_usable_i;
    end
  end

  // Prefix flag: a fit exists at or below this cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_f_q <= 1'b0;
    end else if (ctrl_i.load_scan) begin
      scan_f_q <= valid_i & (usable_q >= req_size_i);
    end else if (ctrl_i.scan_en) begin
      scan_f_q <= scan_f_q | lft_f_i;
    end else if (ctrl_i.apply) begin
      scan_f_q <= 1'b0;
    end
  end

  // Contents of the oldest fit seen so far in this cell's window
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_scan) begin
      scan_d_q <= entry_q;
    end else if (ctrl_i.scan_en && lft_f_i) begin
      scan_d_q <= lft_d_i;
    end
  end

  assign entry_o  = entry_q;
  assign usable_o = usable_q;
  assign scan_f_o = scan_f_q;
  assign scan_d_o = scan_d_q;

endmodule

[rtl/fifo_free_block_cache_core.sv]
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+----------------------------------
// request  | start, busy, req_i             | taken when start && !busy
// result   | res_valid_o, res_o             | one-cycle strobe, never held off
// config   | cfg_we_i, cfg_wdata_i          | cache_limit written when cfg_we_i
//
// A release is done in the accept cycle; its result strobes on the next cycle and busy
// stays low. An allocate runs in steps: one to capture every cell's fit flag,
// log2(MaxEntries) doubling steps of the prefix scan across the cell row, and one to
// remove the fit and report it.
// Reset is asynchronous, active low; it empties the cache and sets the limit to 100.
// The result side cannot stall.
module fifo_free_block_cache_core #(
  parameter int unsigned MaxEntries  = ffbc_pkg::MaxEntriesDef,
  parameter int unsigned HeaderBytes = ffbc_pkg::HeaderBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ffbc_pkg::req_t               req_i,
  output logic                         res_valid_o,
  output ffbc_pkg::res_t               res_o,
  input  logic                         cfg_we_i,
  input  logic [ffbc_pkg::LimitW-1:0]  cfg_wdata_i
);
  import ffbc_pkg::*;

  localparam int unsigned CntW      = $clog2(MaxEntries + 1);
  localparam int unsigned CmpW      = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned ScanSteps = $clog2(MaxEntries);
  localparam int unsigned NbrN      = (ScanSteps > 0) ? ScanSteps : 1;
  localparam int unsigned StepW     = (ScanSteps > 1) ? $clog2(ScanSteps) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'((ScanSteps > 0) ? ScanSteps - 1 : 0);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(MaxEntries);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  state_e              state_q;
  logic [StepW-1:0]    step_q;
  logic [CntW-1:0]     count_q;
  logic [LimitW-1:0]   limit_q;
  logic                res_valid_q;
  res_t                res_q;

  logic                accept;
  logic                do_release;
  logic                do_evict;
  logic [CntW-1:0]     ins_idx;
  logic [CntW-1:0]     rel_count;
  logic [CntW-1:0]     alloc_count;
  logic                hit;
  res_t                rel_res;
  res_t                alloc_res;
  cell_ctrl_t          ctrl;
  entry_t              ins_entry;

  entry_t              cell_entry  [MaxEntries];
  logic [SizeW-1:0]    cell_usable [MaxEntries];
  logic                cell_f      [MaxEntries];
  entry_t              cell_d      [MaxEntries];
  logic                nbr_f       [MaxEntries][NbrN];
  entry_t              nbr_d       [MaxEntries][NbrN];

  // Count, zero-extended or truncated to the result field
  function automatic logic [HeldW-1:0] held(input logic [CntW-1:0] c);
    logic [CmpW-1:0] ext;
    ext = CmpW'(c);
    return ext[HeldW-1:0];
  endfunction

  // Accept and release decode
  assign accept     = start & (state_q == ST_IDLE);
  assign do_release = accept & (req_i.operation == OpRelease) & (req_i.block_handle != '0);
  assign do_evict   = do_release & (count_q != '0) &
                      ((CmpW'(count_q) >= CmpW'(limit_q)) || (count_q >= FullCnt));
  assign ins_idx    = do_evict ? count_q - CntW'(1) : count_q;
  assign rel_count  = do_release ? (do_evict ? count_q : count_q + CntW'(1)) : count_q;
  assign ins_entry  = '{handle: req_i.block_handle, size: req_i.block_bytes};

  // Cell commands
  assign ctrl.load_scan = accept & (req_i.operation == OpAlloc);
  assign ctrl.scan_en   = (state_q == ST_SCAN);
  assign ctrl.apply     = (state_q == ST_APPLY);
  assign ctrl.evict     = do_evict;
  assign ctrl.insert    = do_release;

  // Release result: eviction comes from the oldest cell
  always_comb begin
    rel_res                = '0;
    rel_res.evict_valid    = do_evict;
    rel_res.evicted_handle = do_evict ? cell_entry[0].handle : '0;
    rel_res.evicted_size   = do_evict ? cell_entry[0].size : '0;
    rel_res.entries_held   = held(rel_count);
  end

  // Allocate result: the last cell of the row ends the scan with the oldest fit
  assign hit         = cell_f[MaxEntries-1];
  assign alloc_count = hit ? count_q - CntW'(1) : count_q;

  always_comb begin
    alloc_res               = '0;
    alloc_res.reuse_hit     = hit;
    alloc_res.reused_handle = hit ? cell_d[MaxEntries-1].handle : '0;
    alloc_res.reused_size   = hit ? cell_d[MaxEntries-1].size : '0;
    alloc_res.entries_held  = held(alloc_count);
  end

  // Row of cells; cell 0 holds the oldest entry
  for (genvar gi = 0; gi < MaxEntries; gi++) begin : g_cell
    entry_t           nxt_entry;
    logic [SizeW-1:0] nxt_usable;
    logic             lft_f;
    entry_t           lft_d;

    // Upper neighbor for moving down
    if (gi < MaxEntries - 1) begin : g_nxt
      assign nxt_entry  = cell_entry[gi+1];
      assign nxt_usable = cell_usable[gi+1];
    end else begin : g_last
      assign nxt_entry  = '0;
      assign nxt_usable = '0;
    end

    // Lower neighbors at distance 1, 2, 4, ... for the scan
    for (genvar gk = 0; gk < NbrN; gk++) begin : g_nbr
      if ((gk < ScanSteps) && (gi >= (1 << gk))) begin : g_on
        assign nbr_f[gi][gk] = cell_f[gi-(1<<gk)];
        assign nbr_d[gi][gk] = cell_d[gi-(1<<gk)];
      end else begin : g_off
        assign nbr_f[gi][gk] = 1'b0;
        assign nbr_d[gi][gk] = '0;
      end
    end

    if (NbrN == 1) begin : g_one
      assign lft_f = nbr_f[gi][0];
      assign lft_d = nbr_d[gi][0];
    end else begin : g_sel
      assign lft_f = nbr_f[gi][step_q];
      assign lft_d = nbr_d[gi][step_q];
    end

    ffbc_cell #(
      .HeaderBytes (HeaderBytes)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .valid_i      (count_q > CntW'(gi)),
      .ins_here_i   (ins_idx == CntW'(gi)),
      .ins_entry_i  (ins_entry),
      .req_size_i   (req_i.request_size),
      .nxt_entry_i  (nxt_entry),
      .nxt_usable_i (nxt_usable),
      .lft_f_i      (lft_f),
      .lft_d_i      (lft_d),
      .entry_o      (cell_entry[gi]),
      .usable_o     (cell_usable[gi]),
      .scan_f_o     (cell_f[gi]),
      .scan_d_o     (cell_d[gi])
    );
  end

  // Sequencer, count, limit and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      limit_q     <= LimitReset;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            if (req_i.operation == OpAlloc) begin
              step_q  <= '0;
              state_q <= (ScanSteps == 0) ? ST_APPLY : ST_SCAN;
            end else begin
              res_valid_q <= 1'b1;
              res_q       <= rel_res;
              count_q     <= rel_count;
            end
          end
        end
        ST_SCAN: begin
          if (step_q == LastStep) begin
            state_q <= ST_APPLY;
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end
        ST_APPLY: begin
          res_valid_q <= 1'b1;
          res_q       <= alloc_res;
          count_q     <= alloc_count;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Checks
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("entry count above storage size");

  a_no_res_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !res_valid_q)
    else $error("result strobe during scan");

  a_hit_drops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.reuse_hit) |-> (count_q == $past(count_q) - CntW'(1)))
    else $error("reuse hit did not remove exactly one entry");

  a_hit_excl_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.reuse_hit && res_q.evict_valid))
    else $error("hit and eviction in one transaction");

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.operation == OpAlloc)) |=> busy)
    else $error("allocate did not raise busy");

endmodule

[dv/ffbc_cache_checker.sv]
// Watches the request, result and config channels of the free block cache,
// predicts every result and compares it field by field.
module ffbc_cache_checker
  import ffbc_pkg::*;
#(
  parameter int unsigned MaxEntries  = MaxEntriesDef,
  parameter int unsigned HeaderBytes = HeaderBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  req_t              req_i,
  input  logic              res_valid_i,
  input  res_t              res_i,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  logic              eot_i,
  output int                pending_o,
  output int                fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the cache: index 0 is the oldest block
  entry_t            cached_q[$];
  logic [LimitW-1:0] cache_limit;
  res_t              expected_res_q[$];

  int errors = 0;
  bit eot_seen = 1'b0;

  // Coverage tallies for the closing summary
  int n_allocs = 0, n_hits = 0, n_releases = 0, n_null = 0, n_evicts = 0;
  int n_full_evicts = 0, n_over_limit = 0, peak_held = 0;

  function automatic logic [SizeW-1:0] usable_bytes(logic [SizeW-1:0] total);
    return (total > HeaderBytes) ? total - SizeW'(HeaderBytes) : '0;
  endfunction

  // Applies one transaction to the shadow cache and returns its result
  function automatic res_t predict_cache_step(req_t r);
    res_t o;
    int   fit;
    o   = '0;
    fit = -1;
    if (r.operation == OpAlloc) begin
      n_allocs++;
      for (int i = 0; i < cached_q.size(); i++) begin
        if (fit < 0 && usable_bytes(cached_q[i].size) >= r.request_size) fit = i;
      end
      if (fit >= 0) begin
        o.reuse_hit     = 1'b1;
        o.reused_handle = cached_q[fit].handle;
        o.reused_size   = cached_q[fit].size;
        cached_q.delete(fit);
        n_hits++;
      end
    end else if (r.block_handle != '0) begin
      n_releases++;
      if (cached_q.size() > cache_limit) n_over_limit++;
      if (cached_q.size() > 0 &&
          (cached_q.size() >= cache_limit || cached_q.size() >= MaxEntries)) begin
        // full storage forces an eviction even under a higher limit
        if (cached_q.size() < cache_limit) n_full_evicts++;
        o.evict_valid    = 1'b1;
        o.evicted_handle = cached_q[0].handle;
        o.evicted_size   = cached_q[0].size;
        void'(cached_q.pop_front());
        n_evicts++;
      end
      if (cached_q.size() < MaxEntries) cached_q.push_back('{r.block_handle, r.block_bytes});
    end else begin
      n_null++;
    end
    o.entries_held = HeldW'(cached_q.size());
    if (cached_q.size() > peak_held) peak_held = cached_q.size();
    return o;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Sample every channel at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      cached_q.delete();
      expected_res_q.delete();
      cache_limit = LimitReset;
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (cfg_we_i) cache_limit = cfg_wdata_i;
      if (res_valid_i) begin
        if (expected_res_q.size() == 0) begin
          $display("%0t: result with no transaction pending, actual %p", $time, res_i);
          errors++;
        end else begin
          want = expected_res_q.pop_front();
          check_field("reuse_hit",      want.reuse_hit,      res_i.reuse_hit);
          check_field("reused_handle",  want.reused_handle,  res_i.reused_handle);
          check_field("reused_size",    want.reused_size,    res_i.reused_size);
          check_field("evict_valid",    want.evict_valid,    res_i.evict_valid);
          check_field("evicted_handle", want.evicted_handle, res_i.evicted_handle);
          check_field("evicted_size",   want.evicted_size,   res_i.evicted_size);
          check_field("entries_held",   want.entries_held,   res_i.entries_held);
        end
      end
      if (start_i && !busy_i) expected_res_q.push_back(predict_cache_step(req_i));
      // End of test: anything still expected never arrived
      if (eot_i && !eot_seen) begin
        eot_seen = 1'b1;
        if (expected_res_q.size() != 0) begin
          $display("%0t: %0d expected results never arrived", $time, expected_res_q.size());
          errors += expected_res_q.size();
        end
        $display("covered %0d allocates (%0d hits), %0d releases (%0d null), %0d evictions",
                 n_allocs, n_hits, n_releases + n_null, n_null, n_evicts);
        $display("peak %0d entries, %0d evictions forced by full storage, %0d over-limit releases",
                 peak_held, n_full_evicts, n_over_limit);
      end
      pending_o    <= expected_res_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

[dv/fifo_free_block_cache_core_tb.sv]
// Stimulus and verdict for the free block cache; checking lives in ffbc_cache_checker.
module fifo_free_block_cache_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffbc_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 12;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  req_t              req_i;
  logic              res_valid_o;
  res_t              res_o;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_wdata_i;
  logic              eot;
  int                pending;
  int                fail_count;
  int                stall_cycles = 0;

  always #5ns clk_i = ~clk_i;

  fifo_free_block_cache_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  ffbc_cache_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .res_valid_i  (res_valid_o),
    .res_i        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .eot_i        (eot),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Watchdog: cycles in which no transaction of any kind completes
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog expired at %0t", $time);
      $display("fifo_free_block_cache_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic req_t make_req(logic op, logic [SizeW-1:0] rq,
                                    logic [HandleW-1:0] h, logic [SizeW-1:0] sz);
    req_t r;
    r.operation    = op;
    r.request_size = rq;
    r.block_handle = h;
    r.block_bytes  = sz;
    return r;
  endfunction

  // Sizes cluster around the header so that fits and misses both occur
  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(9))
      7:       return $urandom;
      8:       return 32'hFFFF_FFFF - $urandom_range(0, 80);
      9:       return $urandom_range(0, 1);
      default: return $urandom_range(0, 220);
    endcase
  endfunction

  function automatic req_t rand_item(int rel_pct);
    req_t r;
    r.operation    = ($urandom_range(99) < rel_pct) ? OpRelease : OpAlloc;
    r.request_size = rand_size();
    r.block_handle = HandleW'({$urandom, $urandom});
    r.block_bytes  = rand_size();
    case ($urandom_range(19))
      0:       r.block_handle = '0;
      1:       r.block_handle = HandleW'($urandom_range(1, 15));
      default: ;
    endcase
    return r;
  endfunction

  // Hold start high until the block takes the transaction
  task automatic send_item(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    req_i <= rand_item(50);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic write_limit(logic [LimitW-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(logic [LimitW-1:0] limit, int items, int rel_pct, int gap_pct);
    write_limit(limit);
    for (int n = 0; n < items; n++) begin
      send_item(rand_item(rel_pct));
      while ($urandom_range(99) < gap_pct) pause_sender(1);
      if ($urandom_range(99) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    eot         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cache, null release, field extremes, fit boundary
    send_item(make_req(OpAlloc,   '0, '0, '0));
    send_item(make_req(OpRelease, '1, '0, 32'd77));
    send_item(make_req(OpRelease, '0, '1, '1));
    send_item(make_req(OpRelease, '0, 48'd1, '0));
    send_item(make_req(OpRelease, '0, 48'd2, SizeW'(HeaderBytesDef)));
    send_item(make_req(OpRelease, '0, 48'd3, SizeW'(HeaderBytesDef + 1)));
    send_item(make_req(OpAlloc,   '0, '1, '1));  // zero request takes the oldest
    send_item(make_req(OpAlloc,   32'd1, '0, '0));
    send_item(make_req(OpRelease, '0, 48'd5, '1));
    // one byte past the largest usable size misses, exactly usable hits
    send_item(make_req(OpAlloc, 32'hFFFF_FFFF - HeaderBytesDef + 1, '0, '0));
    send_item(make_req(OpAlloc, 32'hFFFF_FFFF - HeaderBytesDef, '0, '0));

    // Limit of zero: evicts whenever something is cached
    write_limit('0);
    send_item(make_req(OpRelease, '0, 48'd6, 32'd100));
    send_item(make_req(OpAlloc,   '0, '0, '0));
    send_item(make_req(OpAlloc,   '0, '0, '0));
    send_item(make_req(OpRelease, '0, 48'd7, 32'd60));  // empty: insert only
    send_item(make_req(OpRelease, '0, 48'd8, 32'd61));
    write_limit(8'd1);
    send_item(make_req(OpRelease, '0, 48'd9, 32'd62));

    // Limit lowered below the count: one eviction per release only
    write_limit(LimitReset);
    for (int h = 10; h < 16; h++) send_item(make_req(OpRelease, '0, HandleW'(h), 32'd200));
    write_limit(8'd2);
    send_item(make_req(OpRelease, '0, 48'd16, 32'd300));

    // Random: sender idles often, then very often, then never
    run_phase(8'd16,  300, 55, 18);
    run_phase(8'd255, 300, 80, 18);
    run_phase(8'd4,   150, 60, 57);
    run_phase(8'd128, 250, 70, 57);
    run_phase(8'd1,   100, 50, 0);
    run_phase(8'd100, 100, 55, 0);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    eot <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("fifo_free_block_cache_core regression: pass");
    end else begin
      $display("fifo_free_block_cache_core regression: fail");
    end
    $finish;
  end

endmodule

[fifo_free_block_cache_core.f]
rtl/ffbc_pkg.sv
rtl/ffbc_cell.sv
rtl/fifo_free_block_cache_core.sv
dv/ffbc_cache_checker.sv
dv/fifo_free_block_cache_core_tb.sv
